[rtl/core/tree_lca_distance_query_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tree LCA distance query core
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_DISTANCE_QUERY_CORE_MACROS_SVH
`define TREE_LCA_DISTANCE_QUERY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLCDQ_AST_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLCDQ_AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tlcdq_pkg.sv]
// ----------------------------------------------------------------------------
// tlcdq_pkg
// Shared types, widths and command codes of the tree LCA distance query core.
// ----------------------------------------------------------------------------
`default_nettype none

package tlcdq_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;

    localparam int NODE_FW   = 10;
    localparam int WEIGHT_W  = 32;
    localparam int DEPTH_W   = 11;
    localparam int DIST_W    = 42;
    localparam int PATH_W    = 43;

    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [NODE_FW-1:0]  node_a;
        logic [NODE_FW-1:0]  node_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } req_t;

    typedef struct packed {
        logic [NODE_FW-1:0] ancestor_node;
        logic [PATH_W-1:0]  path_distance;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_Q,
        ST_RED_R,
        ST_LD_START,
        ST_LD_META,
        ST_LD_ROW,
        ST_Q_START,
        ST_Q_ORDER,
        ST_LIFT_CHK,
        ST_LIFT_JMP,
        ST_LIFT_DEP,
        ST_EQ_CHK,
        ST_UP_RD,
        ST_UP_CMP,
        ST_PAR_RD,
        ST_PAR_TAKE,
        ST_ANC_RD,
        ST_SUB,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_REDUCE_Q,
        OP_REDUCE_R,
        OP_LD_START,
        OP_LD_META,
        OP_LD_ROW,
        OP_Q_START,
        OP_Q_ORDER,
        OP_LIFT_JUMP,
        OP_LIFT_STEP,
        OP_LIFT_DEPTH,
        OP_SELECT_EQ,
        OP_UP_READ,
        OP_UP_CMP,
        OP_PAR_READ,
        OP_PAR_TAKE,
        OP_ANC_READ,
        OP_SUBTRACT,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_TOP,
        LVL_ONE,
        LVL_INC,
        LVL_DEC
    } lvl_op_t;

    typedef struct packed {
        dp_op_t  op;
        lvl_op_t lvl_op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic load_null;
        logic single_level;
        logic lift_go;
        logic same_node;
        logic out_free;
        logic lvl_zero;
        logic lvl_last;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/tree_lca_distance_query_core.sv]
// ----------------------------------------------------------------------------
// tree_lca_distance_query_core
// Binary-lifting lowest common ancestor and weighted path distance engine.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload           Handshake
// request   in         tlcdq_pkg::req_t  req_valid / req_stall
// result    out        tlcdq_pkg::res_t  res_valid / res_stall
//
// A load writes one jump table entry per level. In a query, a taken lift step
// costs a jump table read and a depth reread.
// Reset clears control only; memories start unwritten and node 0 reads as zero.
// Results sit in an output register, so loads proceed while a result is stalled;
// a query that finishes while that register is still held waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_distance_query_core #(
    parameter int NODES  = tlcdq_pkg::NODES_DEF,
    parameter int LEVELS = tlcdq_pkg::LEVELS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire tlcdq_pkg::req_t req,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output tlcdq_pkg::res_t      res
);

    tlcdq_pkg::dp_cmd_t cmd;
    tlcdq_pkg::dp_sts_t sts;

    tlcdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlcdq_dpath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

[rtl/core/tlcdq_dpath.sv]
// ----------------------------------------------------------------------------
// tlcdq_dpath
// Datapath: node index reduction, jump table, depth and distance memories,
// lifting registers, distance arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlcdq_dpath #(
    parameter int NODES  = tlcdq_pkg::NODES_DEF,
    parameter int LEVELS = tlcdq_pkg::LEVELS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tlcdq_pkg::req_t   req,
    input  wire tlcdq_pkg::dp_cmd_t cmd,
    output tlcdq_pkg::dp_sts_t     sts,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output tlcdq_pkg::res_t        res
);

    localparam int NW       = $clog2(NODES);
    localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JT_DEPTH = NODES * (2 ** LW);
    localparam int RAW_W    = tlcdq_pkg::NODE_FW;
    localparam int DEPTH_W  = tlcdq_pkg::DEPTH_W;
    localparam int DIST_W   = tlcdq_pkg::DIST_W;
    localparam int PATH_W   = tlcdq_pkg::PATH_W;
    localparam int STEP_W   = ((LEVELS > DEPTH_W) ? LEVELS : DEPTH_W) + 1;

    // Reduction by NODES through a reciprocal: the estimate is low by at most one.
    localparam int RECIP_SH   = 2 * RAW_W;
    localparam int PROD_W     = RAW_W + RECIP_SH;
    localparam int RECIP      = (2 ** RECIP_SH) / NODES;
    localparam bit REDUCE     = NODES < (2 ** RAW_W);
    localparam int NODES_CLIP = REDUCE ? NODES : ((2 ** RAW_W) - 1);

    function automatic logic [RAW_W-1:0] quot_est(input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(RECIP);
        return prod[PROD_W-1:RECIP_SH];
    endfunction

    function automatic logic [NW-1:0] node_fix(input logic [RAW_W-1:0] raw,
                                               input logic [RAW_W-1:0] q);
        logic [RAW_W-1:0] rem;
        logic [RAW_W-1:0] adj;
        rem = raw - RAW_W'(q * NODES_CLIP);
        adj = (REDUCE && (rem >= RAW_W'(NODES_CLIP))) ? rem - RAW_W'(NODES_CLIP) : rem;
        return NW'(adj);
    endfunction

    // Memories
    logic [NW-1:0]      jt_mem    [JT_DEPTH];
    logic [DEPTH_W-1:0] depth_mem [NODES];
    logic [DIST_W-1:0]  dist_mem  [NODES];

    // Captured request and working registers
    logic                           opcode_reg;
    logic [RAW_W-1:0]               raw_a_reg;
    logic [RAW_W-1:0]               raw_b_reg;
    logic [tlcdq_pkg::WEIGHT_W-1:0] weight_reg;
    logic [RAW_W-1:0]               qa_reg;
    logic [RAW_W-1:0]               qb_reg;
    logic [NW-1:0]                  x_reg;
    logic [NW-1:0]                  y_reg;
    logic [DEPTH_W-1:0]             depth_x_reg;
    logic [DEPTH_W-1:0]             depth_y_reg;
    logic [PATH_W-1:0]              sum_reg;
    logic [PATH_W-1:0]              path_reg;
    logic [NW-1:0]                  anc_reg;
    logic [LW-1:0]                  lvl_reg;
    logic [LW-1:0]                  lvl_next;
    logic                           res_valid_reg;
    tlcdq_pkg::res_t                res_reg;

    // Registered read ports
    logic [NW-1:0]      jt_a_data_reg;
    logic [NW-1:0]      jt_a_node_reg;
    logic               jt_a_zero_reg;
    logic               jt_a_self_reg;
    logic [NW-1:0]      jt_b_data_reg;
    logic               jt_b_zero_reg;
    logic [DEPTH_W-1:0] depth_a_data_reg;
    logic [DEPTH_W-1:0] depth_b_data_reg;
    logic [DIST_W-1:0]  dist_a_data_reg;
    logic [DIST_W-1:0]  dist_b_data_reg;
    logic               meta_a_zero_reg;
    logic               meta_b_zero_reg;

    // Read values with the sentinel node forced to zero
    logic [NW-1:0]      jt_a_val;
    logic [NW-1:0]      jt_b_val;
    logic [DEPTH_W-1:0] depth_a_val;
    logic [DEPTH_W-1:0] depth_b_val;
    logic [DIST_W-1:0]  dist_a_val;
    logic [DIST_W-1:0]  dist_b_val;

    // Memory controls
    logic               jt_we;
    logic [NW-1:0]      jt_w_node;
    logic [LW-1:0]      jt_w_lvl;
    logic [NW-1:0]      jt_wdata;
    logic               jt_a_en;
    logic [NW-1:0]      jt_a_node;
    logic [LW-1:0]      jt_a_lvl;
    logic               jt_a_self;
    logic               jt_b_en;
    logic [NW-1:0]      jt_b_node;
    logic [LW-1:0]      jt_b_lvl;
    logic               meta_we;
    logic [DEPTH_W-1:0] depth_wdata;
    logic [DIST_W-1:0]  dist_wdata;
    logic               meta_a_en;
    logic [NW-1:0]      meta_a_node;
    logic               meta_b_en;
    logic [NW-1:0]      meta_b_node;

    // When the load reads the row it is writing, the entry just written holds
    // the very node that addressed it, so that node is returned.
    assign jt_a_val    = jt_a_zero_reg ? '0 : (jt_a_self_reg ? jt_a_node_reg : jt_a_data_reg);
    assign jt_b_val    = jt_b_zero_reg ? '0 : jt_b_data_reg;
    assign depth_a_val = meta_a_zero_reg ? '0 : depth_a_data_reg;
    assign depth_b_val = meta_b_zero_reg ? '0 : depth_b_data_reg;
    assign dist_a_val  = meta_a_zero_reg ? '0 : dist_a_data_reg;
    assign dist_b_val  = meta_b_zero_reg ? '0 : dist_b_data_reg;

    always_comb
    begin
        jt_we       = 1'b0;
        jt_w_node   = x_reg;
        jt_w_lvl    = lvl_reg;
        jt_wdata    = jt_a_val;
        jt_a_en     = 1'b0;
        jt_a_node   = x_reg;
        jt_a_lvl    = lvl_reg;
        jt_a_self   = 1'b0;
        jt_b_en     = 1'b0;
        jt_b_node   = y_reg;
        jt_b_lvl    = lvl_reg;
        meta_we     = 1'b0;
        depth_wdata = depth_a_val + DEPTH_W'(1);
        dist_wdata  = dist_a_val + DIST_W'(weight_reg);
        meta_a_en   = 1'b0;
        meta_a_node = x_reg;
        meta_b_en   = 1'b0;
        meta_b_node = y_reg;
        case (cmd.op)
            tlcdq_pkg::OP_LD_START:
            begin
                jt_we       = 1'b1;
                jt_w_lvl    = LW'(0);
                jt_wdata    = y_reg;
                jt_a_en     = 1'b1;
                jt_a_node   = y_reg;
                jt_a_lvl    = LW'(0);
                jt_a_self   = (y_reg == x_reg);
                meta_a_en   = 1'b1;
                meta_a_node = y_reg;
            end
            tlcdq_pkg::OP_LD_META:
            begin
                meta_we = 1'b1;
            end
            tlcdq_pkg::OP_LD_ROW:
            begin
                jt_we     = 1'b1;
                jt_a_en   = 1'b1;
                jt_a_node = jt_a_val;
                jt_a_self = (jt_a_val == x_reg);
            end
            tlcdq_pkg::OP_Q_START:
            begin
                meta_a_en = 1'b1;
                meta_b_en = 1'b1;
            end
            tlcdq_pkg::OP_LIFT_JUMP:
            begin
                jt_b_en = 1'b1;
            end
            tlcdq_pkg::OP_LIFT_STEP:
            begin
                meta_b_en   = 1'b1;
                meta_b_node = jt_b_val;
            end
            tlcdq_pkg::OP_UP_READ:
            begin
                jt_a_en = 1'b1;
                jt_b_en = 1'b1;
            end
            tlcdq_pkg::OP_PAR_READ:
            begin
                jt_a_en  = 1'b1;
                jt_a_lvl = LW'(0);
            end
            tlcdq_pkg::OP_ANC_READ:
            begin
                meta_a_en   = 1'b1;
                meta_a_node = anc_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Jump table: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (jt_we)
        begin
            jt_mem[{jt_w_node, jt_w_lvl}] <= jt_wdata;
        end
        if (jt_a_en)
        begin
            jt_a_data_reg <= jt_mem[{jt_a_node, jt_a_lvl}];
            jt_a_node_reg <= jt_a_node;
            jt_a_zero_reg <= (jt_a_node == '0);
            jt_a_self_reg <= jt_a_self;
        end
        if (jt_b_en)
        begin
            jt_b_data_reg <= jt_mem[{jt_b_node, jt_b_lvl}];
            jt_b_zero_reg <= (jt_b_node == '0);
        end
    end

    // Depth and root distance memories share their addresses
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            depth_mem[x_reg] <= depth_wdata;
            dist_mem[x_reg]  <= dist_wdata;
        end
        if (meta_a_en)
        begin
            depth_a_data_reg <= depth_mem[meta_a_node];
            dist_a_data_reg  <= dist_mem[meta_a_node];
            meta_a_zero_reg  <= (meta_a_node == '0);
        end
        if (meta_b_en)
        begin
            depth_b_data_reg <= depth_mem[meta_b_node];
            dist_b_data_reg  <= dist_mem[meta_b_node];
            meta_b_zero_reg  <= (meta_b_node == '0);
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tlcdq_pkg::OP_CAPTURE:
            begin
                opcode_reg <= req.opcode;
                raw_a_reg  <= req.node_a;
                raw_b_reg  <= req.node_b;
                weight_reg <= req.edge_weight;
            end
            tlcdq_pkg::OP_REDUCE_Q:
            begin
                qa_reg <= quot_est(raw_a_reg);
                qb_reg <= quot_est(raw_b_reg);
            end
            tlcdq_pkg::OP_REDUCE_R:
            begin
                x_reg <= node_fix(raw_a_reg, qa_reg);
                y_reg <= node_fix(raw_b_reg, qb_reg);
            end
            tlcdq_pkg::OP_Q_ORDER:
            begin
                sum_reg <= PATH_W'(dist_a_val) + PATH_W'(dist_b_val);
                if (depth_a_val > depth_b_val)
                begin
                    x_reg       <= y_reg;
                    y_reg       <= x_reg;
                    depth_x_reg <= depth_b_val;
                    depth_y_reg <= depth_a_val;
                end
                else
                begin
                    depth_x_reg <= depth_a_val;
                    depth_y_reg <= depth_b_val;
                end
            end
            tlcdq_pkg::OP_LIFT_STEP:
            begin
                y_reg <= jt_b_val;
            end
            tlcdq_pkg::OP_LIFT_DEPTH:
            begin
                depth_y_reg <= depth_b_val;
            end
            tlcdq_pkg::OP_SELECT_EQ:
            begin
                anc_reg <= x_reg;
            end
            tlcdq_pkg::OP_UP_CMP:
            begin
                if (jt_a_val != jt_b_val)
                begin
                    x_reg <= jt_a_val;
                    y_reg <= jt_b_val;
                end
            end
            tlcdq_pkg::OP_PAR_TAKE:
            begin
                anc_reg <= jt_a_val;
            end
            tlcdq_pkg::OP_SUBTRACT:
            begin
                path_reg <= sum_reg - {dist_a_val, 1'b0};
            end
            tlcdq_pkg::OP_EMIT:
            begin
                res_reg.ancestor_node <= RAW_W'(anc_reg);
                res_reg.path_distance <= path_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (cmd.lvl_op)
            tlcdq_pkg::LVL_TOP:  lvl_next = LW'(LEVELS - 1);
            tlcdq_pkg::LVL_ONE:  lvl_next = LW'(1);
            tlcdq_pkg::LVL_INC:  lvl_next = lvl_reg + LW'(1);
            tlcdq_pkg::LVL_DEC:  lvl_next = lvl_reg - LW'(1);
            default:             lvl_next = lvl_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            lvl_reg <= lvl_next;
            if (cmd.op == tlcdq_pkg::OP_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.is_query     = (opcode_reg == tlcdq_pkg::OPC_QUERY);
        sts.load_null    = (x_reg == '0);
        sts.single_level = (LEVELS == 1);
        sts.lift_go      = (STEP_W'(depth_x_reg) + (STEP_W'(1) << lvl_reg))
                           <= STEP_W'(depth_y_reg);
        sts.same_node    = (x_reg == y_reg);
        sts.out_free     = !res_valid_reg || !res_stall;
        sts.lvl_zero     = (lvl_reg == '0);
        sts.lvl_last     = (lvl_reg == LW'(LEVELS - 1));
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/core/tlcdq_ctrl.sv]
// ----------------------------------------------------------------------------
// tlcdq_ctrl
// Controller: sequences loads and queries by issuing datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_lca_distance_query_core_macros.svh"

module tlcdq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire tlcdq_pkg::dp_sts_t sts,
    output tlcdq_pkg::dp_cmd_t      cmd
);

    tlcdq_pkg::ctrl_state_t state_reg;
    tlcdq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlcdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tlcdq_pkg::OP_NOP;
        cmd.lvl_op = tlcdq_pkg::LVL_HOLD;
        req_stall  = (state_reg != tlcdq_pkg::ST_IDLE);
        case (state_reg)
            tlcdq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = tlcdq_pkg::OP_CAPTURE;
                    state_next = tlcdq_pkg::ST_RED_Q;
                end
            end
            tlcdq_pkg::ST_RED_Q:
            begin
                cmd.op     = tlcdq_pkg::OP_REDUCE_Q;
                state_next = tlcdq_pkg::ST_RED_R;
            end
            tlcdq_pkg::ST_RED_R:
            begin
                cmd.op     = tlcdq_pkg::OP_REDUCE_R;
                state_next = sts.is_query ? tlcdq_pkg::ST_Q_START : tlcdq_pkg::ST_LD_START;
            end
            tlcdq_pkg::ST_LD_START:
            begin
                // The sentinel node is never overwritten.
                if (sts.load_null)
                begin
                    state_next = tlcdq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op     = tlcdq_pkg::OP_LD_START;
                    state_next = tlcdq_pkg::ST_LD_META;
                end
            end
            tlcdq_pkg::ST_LD_META:
            begin
                cmd.op     = tlcdq_pkg::OP_LD_META;
                cmd.lvl_op = tlcdq_pkg::LVL_ONE;
                state_next = sts.single_level ? tlcdq_pkg::ST_IDLE : tlcdq_pkg::ST_LD_ROW;
            end
            tlcdq_pkg::ST_LD_ROW:
            begin
                cmd.op = tlcdq_pkg::OP_LD_ROW;
                if (sts.lvl_last)
                begin
                    state_next = tlcdq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.lvl_op = tlcdq_pkg::LVL_INC;
                end
            end
            tlcdq_pkg::ST_Q_START:
            begin
                cmd.op     = tlcdq_pkg::OP_Q_START;
                state_next = tlcdq_pkg::ST_Q_ORDER;
            end
            tlcdq_pkg::ST_Q_ORDER:
            begin
                cmd.op     = tlcdq_pkg::OP_Q_ORDER;
                cmd.lvl_op = tlcdq_pkg::LVL_TOP;
                state_next = tlcdq_pkg::ST_LIFT_CHK;
            end
            tlcdq_pkg::ST_LIFT_CHK:
            begin
                if (sts.lift_go)
                begin
                    cmd.op     = tlcdq_pkg::OP_LIFT_JUMP;
                    state_next = tlcdq_pkg::ST_LIFT_JMP;
                end
                else if (sts.lvl_zero)
                begin
                    state_next = tlcdq_pkg::ST_EQ_CHK;
                end
                else
                begin
                    cmd.lvl_op = tlcdq_pkg::LVL_DEC;
                end
            end
            tlcdq_pkg::ST_LIFT_JMP:
            begin
                cmd.op     = tlcdq_pkg::OP_LIFT_STEP;
                state_next = tlcdq_pkg::ST_LIFT_DEP;
            end
            tlcdq_pkg::ST_LIFT_DEP:
            begin
                // The depth of the new deeper node is reread, not derived.
                cmd.op = tlcdq_pkg::OP_LIFT_DEPTH;
                if (sts.lvl_zero)
                begin
                    state_next = tlcdq_pkg::ST_EQ_CHK;
                end
                else
                begin
                    cmd.lvl_op = tlcdq_pkg::LVL_DEC;
                    state_next = tlcdq_pkg::ST_LIFT_CHK;
                end
            end
            tlcdq_pkg::ST_EQ_CHK:
            begin
                if (sts.same_node)
                begin
                    cmd.op     = tlcdq_pkg::OP_SELECT_EQ;
                    state_next = tlcdq_pkg::ST_ANC_RD;
                end
                else
                begin
                    cmd.lvl_op = tlcdq_pkg::LVL_TOP;
                    state_next = tlcdq_pkg::ST_UP_RD;
                end
            end
            tlcdq_pkg::ST_UP_RD:
            begin
                cmd.op     = tlcdq_pkg::OP_UP_READ;
                state_next = tlcdq_pkg::ST_UP_CMP;
            end
            tlcdq_pkg::ST_UP_CMP:
            begin
                cmd.op = tlcdq_pkg::OP_UP_CMP;
                if (sts.lvl_zero)
                begin
                    state_next = tlcdq_pkg::ST_PAR_RD;
                end
                else
                begin
                    cmd.lvl_op = tlcdq_pkg::LVL_DEC;
                    state_next = tlcdq_pkg::ST_UP_RD;
                end
            end
            tlcdq_pkg::ST_PAR_RD:
            begin
                cmd.op     = tlcdq_pkg::OP_PAR_READ;
                state_next = tlcdq_pkg::ST_PAR_TAKE;
            end
            tlcdq_pkg::ST_PAR_TAKE:
            begin
                cmd.op     = tlcdq_pkg::OP_PAR_TAKE;
                state_next = tlcdq_pkg::ST_ANC_RD;
            end
            tlcdq_pkg::ST_ANC_RD:
            begin
                cmd.op     = tlcdq_pkg::OP_ANC_READ;
                state_next = tlcdq_pkg::ST_SUB;
            end
            tlcdq_pkg::ST_SUB:
            begin
                cmd.op     = tlcdq_pkg::OP_SUBTRACT;
                state_next = tlcdq_pkg::ST_EMIT;
            end
            tlcdq_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = tlcdq_pkg::OP_EMIT;
                    state_next = tlcdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlcdq_pkg::ST_IDLE;
            end
        endcase
    end

    `TLCDQ_AST_NOW(a_emit_free, cmd.op == tlcdq_pkg::OP_EMIT, sts.out_free, "result overwritten while held")
    `TLCDQ_AST_NEXT(a_accept_starts, (state_reg == tlcdq_pkg::ST_IDLE) && req_valid, state_reg == tlcdq_pkg::ST_RED_Q, "accepted request not started")
    `TLCDQ_AST_NEXT(a_row_ends, (state_reg == tlcdq_pkg::ST_LD_ROW) && sts.lvl_last, state_reg == tlcdq_pkg::ST_IDLE, "load row runs past last level")
    `TLCDQ_AST_NOW(a_lift_done, state_reg == tlcdq_pkg::ST_EQ_CHK, sts.lvl_zero, "lifting left before level zero")

endmodule

`default_nettype wire
